### sv/rms_pkg.sv
// Shared types and constants for the running median block.
`default_nettype none

package rms_pkg;

   // Widths of the fields carried on the streams.
   localparam int SAMPLE_BITS = 32;
   localparam int MEDIAN_BITS = 32;
   localparam int SUM_BITS    = 64;
   localparam int HELD_BITS   = 11;

   // Result tdata layout, lowest field first, padded to whole bytes.
   localparam int MEDIAN_LSB     = 0;
   localparam int SUM_LSB        = MEDIAN_LSB + MEDIAN_BITS;
   localparam int HELD_LSB       = SUM_LSB + SUM_BITS;
   localparam int RSP_USED_BITS  = HELD_LSB + HELD_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_USED_BITS;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TREE = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

endpackage

`default_nettype wire

### sv/rms_cell.sv
// One cell of the sorted insertion row: holds a single sorted entry.
`default_nettype none

module rms_cell
   #(
      parameter int WIDTH       = 32,
      parameter int COUNT_WIDTH = 11,
      parameter int INDEX       = 0
   )
   (
      input  wire logic                    clock,
      input  wire logic                    insert,
      input  wire logic [COUNT_WIDTH-1:0]  count,
      input  wire logic [COUNT_WIDTH-1:0]  med_idx,
      input  wire logic signed [WIDTH-1:0] sample,
      input  wire logic signed [WIDTH-1:0] left_value,
      input  wire logic                    left_greater,
      output logic signed [WIDTH-1:0]      value,
      output logic                         greater,
      output logic [WIDTH-1:0]             tap
   );

   localparam logic [COUNT_WIDTH-1:0] MY_INDEX = COUNT_WIDTH'(INDEX);

   logic signed [WIDTH-1:0] value_ff;
   logic signed [WIDTH-1:0] value_in;
   logic                    occupied;
   logic                    at_end;

   // The entry is live when it lies below the fill level.
   assign occupied = MY_INDEX < count;
   assign at_end   = MY_INDEX == count;
   assign greater  = occupied && (value_ff > sample);

   // Shift right when the left neighbour yields, take the sample at the insertion point.
   always_comb begin
      value_in = value_ff;
      if (insert) begin
         if (left_greater) begin
            value_in = left_value;
         end else if (greater || at_end) begin
            value_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // Offer the entry to the read-out tree when it is the median.
   assign tap   = (MY_INDEX == med_idx) ? value_ff : '0;
   assign value = value_ff;

endmodule

`default_nettype wire

### sv/rms_tree.sv
// Registered OR tree that gathers the one selected cell entry.
`default_nettype none

module rms_tree
   #(
      parameter int WIDTH  = 32,
      parameter int LEAVES = 1024
   )
   (
      input  wire logic             clock,
      input  wire logic [WIDTH-1:0] tap [LEAVES],
      output logic [WIDTH-1:0]      root
   );

   localparam int LEVELS = $clog2(LEAVES);
   localparam int NODES  = 1 << LEVELS;

   logic [WIDTH-1:0] node_ff [1:2*NODES-1];

   // Leaf registers; padding leaves stay at zero.
   for (genvar j = 0; j < NODES; j++) begin : g_leaf
      if (j < LEAVES) begin : g_used
         always_ff @(posedge clock) begin
            node_ff[NODES+j] <= tap[j];
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_ff[NODES+j] <= '0;
         end
      end
   end

   // Each inner node merges its two children one level per cycle.
   for (genvar i = 1; i < NODES; i++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[i] <= node_ff[2*i] | node_ff[2*i+1];
      end
   end

   assign root = node_ff[1];

endmodule

`default_nettype wire

### sv/running_median_sum.sv
// Top level of the running lower-median and median-sum block.
//
// Each input transfer carries one signed sample (req_tdata) and a restart flag
// (req_tuser). The samples are kept in ascending order in a row of DEPTH cells;
// an accepted sample is inserted into the registered row, the larger entries moving one
// cell to the right. The lower median is then read out of the row through a
// registered OR tree, and the block handles one item at a time: the sample is
// inserted, the median passes the leaf and node registers of the read-out
// tree, and the median is added to the running sum once the output register
// is free. A new sample is taken while the previous result still waits on the
// output register. Once DEPTH samples are held, further samples are discarded
// and flagged until a restart. The store needs no clearing after reset.
`default_nettype none

module running_median_sum
   import rms_pkg::*;
   #(
      parameter int DEPTH        = 1024,
      parameter int SAMPLE_WIDTH = 32
   )
   (
      input  wire logic                     clock,
      input  wire logic                     reset,
      input  wire logic                     req_tvalid,
      output logic                          req_tready,
      input  wire logic [SAMPLE_BITS-1:0]   req_tdata,  // [31:0] sample
      input  wire logic [0:0]               req_tuser,  // [0] restart
      output logic                          rsp_tvalid,
      input  wire logic                     rsp_tready,
      output logic [RSP_DATA_BITS-1:0]      rsp_tdata,  // [31:0] median, [95:32] median_sum,
                                                        // [106:96] held_count, rest zero
      output logic [0:0]                    rsp_tuser   // [0] dropped
   );

   localparam int CW        = $clog2(DEPTH + 1);
   localparam int LEVELS    = $clog2(DEPTH);
   localparam int TW        = $clog2(LEVELS + 2);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [TW-1:0] TREE_LAST  = TW'(LEVELS);

   state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TW-1:0]       tick_ff, tick_in;
   logic                restart_ff, restart_in;
   logic                dropped_ff, dropped_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic [HELD_BITS-1:0]   rsp_held_ff, rsp_held_in;
   logic                   rsp_dropped_ff, rsp_dropped_in;

   logic                           accept;
   logic [CW-1:0]                  base_count;
   logic                           full;
   logic                           insert;
   logic [CW-1:0]                  med_idx;
   logic signed [SAMPLE_WIDTH-1:0] sample_ext;
   logic [SAMPLE_WIDTH-1:0]        root;
   logic [MEDIAN_BITS-1:0]         median_narrow;
   logic [SUM_BITS-1:0]            median_wide;
   logic [HELD_BITS-1:0]           held_count;
   logic                           out_free;

   logic signed [SAMPLE_WIDTH-1:0] value_w   [DEPTH];
   logic                           greater_w [DEPTH];
   logic [SAMPLE_WIDTH-1:0]        tap_w     [DEPTH];

   // Bring the sample to the stored width.
   if (SAMPLE_WIDTH <= SAMPLE_BITS) begin : g_sample_narrow
      assign sample_ext = req_tdata[SAMPLE_WIDTH-1:0];
   end else begin : g_sample_wide
      assign sample_ext = {{(SAMPLE_WIDTH-SAMPLE_BITS){1'b0}}, req_tdata};
   end

   // Fit the median to the output field and to the sum.
   if (SAMPLE_WIDTH >= MEDIAN_BITS) begin : g_med_trunc
      assign median_narrow = root[MEDIAN_BITS-1:0];
   end else begin : g_med_ext
      assign median_narrow = {{(MEDIAN_BITS-SAMPLE_WIDTH){root[SAMPLE_WIDTH-1]}}, root};
   end
   if (SAMPLE_WIDTH >= SUM_BITS) begin : g_wide_full
      assign median_wide = root[SUM_BITS-1:0];
   end else begin : g_wide_ext
      assign median_wide = {{(SUM_BITS-SAMPLE_WIDTH){root[SAMPLE_WIDTH-1]}}, root};
   end

   // The held count is reported modulo the field width.
   if (CW >= HELD_BITS) begin : g_held_trunc
      assign held_count = count_ff[HELD_BITS-1:0];
   end else begin : g_held_ext
      assign held_count = {{(HELD_BITS-CW){1'b0}}, count_ff};
   end

   // Input handshake and insertion decision.
   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign base_count = req_tuser[0] ? '0 : count_ff;
   assign full       = base_count >= FULL_COUNT;
   assign insert     = accept && !full;
   assign med_idx    = (count_ff - CW'(1)) >> 1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Row of sorted cells.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] left_value;
      logic                           left_greater;
      if (i == 0) begin : g_first
         assign left_value   = '0;
         assign left_greater = 1'b0;
      end else begin : g_inner
         assign left_value   = value_w[i-1];
         assign left_greater = greater_w[i-1];
      end
      rms_cell #(
         .WIDTH       (SAMPLE_WIDTH),
         .COUNT_WIDTH (CW),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .insert       (insert),
         .count        (base_count),
         .med_idx      (med_idx),
         .sample       (sample_ext),
         .left_value   (left_value),
         .left_greater (left_greater),
         .value        (value_w[i]),
         .greater      (greater_w[i]),
         .tap          (tap_w[i])
      );
   end

   // Median read-out.
   rms_tree #(
      .WIDTH  (SAMPLE_WIDTH),
      .LEAVES (DEPTH)
   ) u_tree (
      .clock (clock),
      .tap   (tap_w),
      .root  (root)
   );

   // Sequencer, count, running sum and output register.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      tick_in        = tick_ff;
      restart_in     = restart_ff;
      dropped_in     = dropped_ff;
      sum_in         = sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_median_in  = rsp_median_ff;
      rsp_held_in    = rsp_held_ff;
      rsp_dropped_in = rsp_dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               restart_in = req_tuser[0];
               dropped_in = full;
               count_in   = full ? base_count : base_count + CW'(1);
               tick_in    = '0;
               state_in   = ST_TREE;
            end
         end
         ST_TREE: begin
            tick_in = tick_ff + TW'(1);
            if (tick_ff == TREE_LAST) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (out_free) begin
               sum_in = (restart_ff ? '0 : sum_ff) + (dropped_ff ? '0 : median_wide);
               rsp_valid_in   = 1'b1;
               rsp_median_in  = median_narrow;
               rsp_held_in    = held_count;
               rsp_dropped_in = dropped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tick_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff     <= restart_in;
      dropped_ff     <= dropped_in;
      rsp_median_ff  <= rsp_median_in;
      rsp_held_ff    <= rsp_held_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, rsp_held_ff, sum_ff, rsp_median_ff};
   assign rsp_tuser  = rsp_dropped_ff;

endmodule

`default_nettype wire

### sv/rms_checker.sv
// Port-level checks for the running median block, bound to its top level.
`default_nettype none

module rms_checker
   import rms_pkg::*;
   #(
      parameter int DEPTH = 1024
   )
   (
      input wire logic                     clock,
      input wire logic                     reset,
      input wire logic                     req_tvalid,
      input wire logic                     req_tready,
      input wire logic                     rsp_tvalid,
      input wire logic                     rsp_tready,
      input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
      input wire logic [0:0]               rsp_tuser
   );

   localparam logic [HELD_BITS-1:0] FULL_HELD = HELD_BITS'(DEPTH);
   localparam bit COUNT_FITS = DEPTH < (1 << HELD_BITS);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // The block does not take a second sample straight after a transfer.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken straight after a transfer");

   // A discarded sample means the store is full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[HELD_LSB+HELD_BITS-1:HELD_LSB] == FULL_HELD)
      else $error("sample dropped while store not full");

   // With a single held sample the sum equals that sample.
   a_first_sum: assert property (@(posedge clock) disable iff (reset)
      COUNT_FITS && rsp_tvalid &&
      rsp_tdata[HELD_LSB+HELD_BITS-1:HELD_LSB] == HELD_BITS'(1) |->
         rsp_tdata[SUM_LSB+MEDIAN_BITS-1:SUM_LSB] ==
         rsp_tdata[MEDIAN_LSB+MEDIAN_BITS-1:MEDIAN_LSB])
      else $error("sum differs from the only median");

endmodule

bind running_median_sum rms_checker #(.DEPTH(DEPTH)) u_rms_checker (.*);

`default_nettype wire

### tb/running_median_sum_tb.sv
// Self-checking testbench for the running lower-median and median-sum block.
module running_median_sum_tb;
   import rms_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int CALM_ITEMS  = 100;     // final stretch of the run with no random gaps
   localparam int FILL_RUN    = 1040;    // long run that overfills the store

   // One sample as the sender will present it.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   restart;
      bit                     drain;     // wait for every result before sending
   } sample_item_type;

   // One result as the block should report it.
   typedef struct packed {
      logic [MEDIAN_BITS-1:0] median;
      logic [SUM_BITS-1:0]    total;
      logic [HELD_BITS-1:0]   held;
      logic                   dropped;
   } median_result_type;

   logic                     clock;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [SAMPLE_BITS-1:0]   req_tdata  = '0;   // [31:0] sample
   logic [0:0]               req_tuser  = '0;   // [0] restart
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // [31:0] median, [95:32] median_sum,
                                                // [106:96] held_count, rest zero
   logic [0:0]               rsp_tuser;         // [0] dropped

   sample_item_type        sample_feed[$];
   median_result_type      median_due[$];
   logic signed [31:0]     sorted_vals[$];
   logic [SUM_BITS-1:0]    median_total = '0;

   logic                   req_taken = 1'b0;
   int unsigned            req_gap   = 0;
   int unsigned            rsp_gap   = 0;
   int unsigned            error_count    = 0;
   int unsigned            samples_taken  = 0;
   int unsigned            restarts_taken = 0;
   int unsigned            results_seen   = 0;
   int unsigned            drops_seen     = 0;

   running_median_sum #(
      .DEPTH        (STORE_DEPTH),
      .SAMPLE_WIDTH (SAMPLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Inserts a sample into the sorted copy and works out the block's answer.
   function automatic median_result_type take_sample(logic [SAMPLE_BITS-1:0] sample,
                                                     logic restart);
      median_result_type  res;
      logic signed [31:0] value;
      logic [31:0]        med;
      int                 pos;
      value = sample;
      if (restart) begin
         sorted_vals.delete();
         median_total = '0;
      end
      res.dropped = (sorted_vals.size() >= STORE_DEPTH);
      if (!res.dropped) begin
         pos = 0;
         while (pos < sorted_vals.size() && sorted_vals[pos] <= value)
            pos++;
         sorted_vals.insert(pos, value);
      end
      med = sorted_vals[(sorted_vals.size() - 1) / 2];
      if (!res.dropped)
         median_total = median_total + {{32{med[31]}}, med};
      res.median = med;
      res.total  = median_total;
      res.held   = HELD_BITS'(sorted_vals.size());
      return res;
   endfunction

   // Wide random values half of the time, with extremes and a narrow band to force ties.
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic [SAMPLE_BITS-1:0] value;
      case ($urandom_range(0, 9))
         0:       value = 32'h8000_0000;
         1:       value = 32'h7FFF_FFFF;
         2, 3:    value = $urandom_range(0, 8) - 4;
         4:       value = {32{$urandom_range(0, 1) == 1}};
         default: value = $urandom();
      endcase
      return value;
   endfunction

   task automatic queue_sample(logic [SAMPLE_BITS-1:0] sample, logic restart, bit drain);
      sample_item_type item;
      item.sample  = sample;
      item.restart = restart;
      item.drain   = drain;
      sample_feed.insert(sample_feed.size(), item);
   endtask

   // Sender: presents the next pending sample, with random gaps and drain pauses.
   always @(negedge clock) begin : req_driver
      sample_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap != 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (sample_feed.size() == 0 ||
                      (sample_feed[0].drain && median_due.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else if (sample_feed.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 10);
            req_tvalid <= 1'b0;
         end else begin
            item = sample_feed.pop_front();
            req_tdata  <= item.sample;
            req_tuser  <= item.restart;
            req_tvalid <= 1'b1;
         end
      end
   end

   // Receiver: holds off results in random bursts until the calm stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (sample_feed.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on every input transfer and checks every result transfer.
   always @(posedge clock) begin : rsp_monitor
      median_result_type      want;
      logic [MEDIAN_BITS-1:0] got_median;
      logic [SUM_BITS-1:0]    got_total;
      logic [HELD_BITS-1:0]   got_held;
      if (!reset) begin
         req_taken <= (req_tvalid === 1'b1 && req_tready === 1'b1);
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            median_due.insert(median_due.size(), take_sample(req_tdata, req_tuser[0]));
            samples_taken++;
            if (req_tuser[0])
               restarts_taken++;
         end
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            results_seen++;
            got_median = rsp_tdata[MEDIAN_LSB +: MEDIAN_BITS];
            got_total  = rsp_tdata[SUM_LSB +: SUM_BITS];
            got_held   = rsp_tdata[HELD_LSB +: HELD_BITS];
            if (median_due.size() == 0) begin
               $error("result transfer with no result outstanding");
               error_count++;
            end else begin
               want = median_due.pop_front();
               if (want.dropped)
                  drops_seen++;
               if (got_median !== want.median) begin
                  $error("median: expected %0d, got %0d",
                         $signed(want.median), $signed(got_median));
                  error_count++;
               end
               if (got_total !== want.total) begin
                  $error("median_sum: expected %0d, got %0d",
                         $signed(want.total), $signed(got_total));
                  error_count++;
               end
               if (got_held !== want.held) begin
                  $error("held_count: expected %0d, got %0d", want.held, got_held);
                  error_count++;
               end
               if (rsp_tuser[0] !== want.dropped) begin
                  $error("dropped: expected %0b, got %0b", want.dropped, rsp_tuser[0]);
                  error_count++;
               end
               if ((rsp_tdata >> RSP_USED_BITS) !== '0) begin
                  $error("padding: expected 0, got %0h", rsp_tdata >> RSP_USED_BITS);
                  error_count++;
               end
            end
         end
      end
   end

   // Stimulus, reset and the end of the run.
   initial begin
      // Extremes, ties, negative sums and restarts on a partly filled store.
      queue_sample(32'h8000_0000, 1'b0, 1'b0);
      queue_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_sample(32'h0000_0000, 1'b0, 1'b0);
      queue_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_sample(32'h0000_0001, 1'b0, 1'b0);
      repeat (3) queue_sample(32'd5, 1'b0, 1'b0);
      queue_sample(32'd5, 1'b1, 1'b1);
      queue_sample(32'd5, 1'b0, 1'b0);
      repeat (3) queue_sample(32'h8000_0000, 1'b0, 1'b0);
      queue_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
      repeat (2) queue_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_sample(32'hAAAA_AAAA, 1'b1, 1'b0);
      queue_sample(32'h5555_5555, 1'b0, 1'b0);
      queue_sample(32'hFFFF_FFFF, 1'b1, 1'b1);

      // One long run that fills the store and then has samples discarded.
      for (int i = 0; i < FILL_RUN; i++)
         queue_sample(pick_sample(), i == 0, i == STORE_DEPTH);

      // Shorter runs split by random restarts, the first on a full store.
      for (int i = 0; i < 110; i++)
         queue_sample(pick_sample(), i == 0 || $urandom_range(0, 11) == 0,
                      $urandom_range(0, 39) == 0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (sample_feed.size() != 0 || req_tvalid === 1'b1)
         @(posedge clock);
      while (median_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Run covered %0d samples with %0d restarts; %0d results checked,",
               samples_taken, restarts_taken, results_seen);
      $display("%0d of them for samples discarded at a full store.", drops_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
sv/rms_pkg.sv
sv/rms_cell.sv
sv/rms_tree.sv
sv/running_median_sum.sv
sv/rms_checker.sv
tb/running_median_sum_tb.sv
